// File: design/rtc3w_pkg.sv
// Shared types, constants and helpers for the three-wire clock-chip register master.
`default_nettype none
package rtc3w_pkg;

  localparam logic [7:0] CMD_WRITE  = 8'h80;
  localparam logic [7:0] CMD_READ   = 8'h81;
  localparam int unsigned CMD_BITS  = 8;
  localparam int unsigned DATA_BITS = 16;
  localparam int unsigned CNT_W     = $clog2(DATA_BITS);
  localparam logic [6:0] DEC_MAX    = 7'd99;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e      mode;
    logic [4:0] reg_index;
    logic [6:0] value_dec;
    logic       data_pin;
  } in_item_t;

  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       data_out;
    logic       data_drive;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       busy_res;
    logic       start_rejected;
  } out_item_t;

  // Saturate to 99 and split into two BCD digits; tens = (v * 103) >> 10 holds for v <= 99.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [6:0]  sat;
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    sat  = (v > DEC_MAX) ? DEC_MAX : v;
    prod = {7'd0, sat} * 14'd103;
    tens = prod[13:10];
    ones = sat - 7'({3'd0, tens} * 7'd10);
    return {tens, ones[3:0]};
  endfunction

endpackage
`default_nettype wire

// File: design/three_wire_rtc_register_access.sv
// Top level: three-wire serial master that sequences clock-chip register writes and reads.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------------
//  in      | input     | in_valid_i / in_ready_o  | in_data_i  (in_item_t)
//  out     | output    | out_valid_o / out_ready_i| out_data_o (out_item_t)
//
// Every item yields one result item, registered when the item is accepted.
// One item is accepted per cycle unless the output stalls; the sequencer state and the result register
// advance together, so throughput is set by the single output register.
// A stalled output holds the result; the input is taken again once it drains.
// Reset clears the sequencer to idle and empties the output register.
`default_nettype none
module three_wire_rtc_register_access
  import rtc3w_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              half_q, half_d;
  logic [15:0]       oshift_q, oshift_d;
  logic [7:0]        ishift_q, ishift_d;
  logic              is_read_q, is_read_d;
  logic              out_valid_q;
  out_item_t         out_q, res_d;
  logic              accept;
  logic              rejected;
  logic              done_read;
  logic              listen_d;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sequencer next state
  always_comb begin
    busy_d    = busy_q;
    cnt_d     = cnt_q;
    half_d    = half_q;
    oshift_d  = oshift_q;
    ishift_d  = ishift_q;
    is_read_d = is_read_q;
    rejected  = 1'b0;
    done_read = 1'b0;
    unique case (in_data_i.mode)
      MODE_WRITE, MODE_READ: begin
        if (busy_q) begin
          rejected = 1'b1;
        end else begin
          busy_d   = 1'b1;
          cnt_d    = '0;
          half_d   = 1'b0;
          ishift_d = '0;
          if (in_data_i.mode == MODE_WRITE) begin
            is_read_d = 1'b0;
            oshift_d  = {to_bcd(in_data_i.value_dec), CMD_WRITE | {2'b00, in_data_i.reg_index, 1'b0}};
          end else begin
            is_read_d = 1'b1;
            oshift_d  = {8'h00, CMD_READ | {2'b00, in_data_i.reg_index, 1'b0}};
          end
        end
      end
      MODE_TICK: begin
        if (busy_q) begin
          if (!half_q) begin
            // sample on the rising clock of each data bit
            if (is_read_q && cnt_q[CNT_W-1]) begin
              ishift_d[cnt_q[2:0]] = in_data_i.data_pin;
            end
            half_d = 1'b1;
          end else begin
            half_d = 1'b0;
            cnt_d  = cnt_q + 1'b1;
            if (&cnt_q) begin
              done_read = is_read_q;
              busy_d    = 1'b0;
              cnt_d     = '0;
            end
          end
        end
      end
      MODE_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // Pin levels after the item
  assign listen_d = is_read_d && cnt_d[CNT_W-1];

  always_comb begin
    res_d                = '0;
    res_d.chip_enable    = busy_d;
    res_d.serial_clock   = busy_d && half_d;
    res_d.data_out       = busy_d && !listen_d && oshift_d[cnt_d];
    res_d.data_drive     = busy_d && !listen_d;
    res_d.read_byte      = done_read ? ishift_d : 8'h00;
    res_d.read_valid     = done_read;
    res_d.busy_res       = busy_d;
    res_d.start_rejected = rejected;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      half_q      <= 1'b0;
      oshift_q    <= '0;
      ishift_q    <= '0;
      is_read_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q    <= busy_d;
        cnt_q     <= cnt_d;
        half_q    <= half_d;
        oshift_q  <= oshift_d;
        ishift_q  <= ishift_d;
        is_read_q <= is_read_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res_d;
    end
  end

`ifndef SYNTH
  a_ce_tracks_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.chip_enable == out_data_o.busy_res))
    else $error("chip enable differs from busy");

  a_read_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.read_valid) |-> (!out_data_o.busy_res && !busy_q))
    else $error("read completed while still busy");

  a_start_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !busy_q && (in_data_i.mode == MODE_WRITE || in_data_i.mode == MODE_READ))
    |=> (busy_q && out_data_o.busy_res && !out_data_o.start_rejected))
    else $error("start from idle did not begin a transaction");

  a_idle_counters_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (cnt_q == '0 && !half_q))
    else $error("bit counter or half period left set while idle");
`endif

endmodule
`default_nettype wire
